### hdl/fbmp_pkg.sv
// Shared constants, product codes and controller/datapath interface types for the Fibonacci block.
package fbmp_pkg;

  // Field widths
  localparam int unsigned IndexW = 32;
  localparam int unsigned FibW   = 64;

  // Default exponent width and last index whose Fibonacci number fits in 64 bits
  localparam int unsigned DefIndexBits = 32;
  localparam logic [IndexW-1:0] FibLastExact = 32'd93;

  // Product codes: which pair of matrix entries goes into the multiplier.
  // Bits [2:1] name the target entry, bit [0] the first or second term of its sum.
  localparam int unsigned OpW = 3;
  localparam logic [OpW-1:0] OP_ACC_B_0 = 3'd0;  // acc.a  * base.b
  localparam logic [OpW-1:0] OP_ACC_B_1 = 3'd1;  // acc.b  * base.d
  localparam logic [OpW-1:0] OP_ACC_D_0 = 3'd2;  // acc.b  * base.b
  localparam logic [OpW-1:0] OP_ACC_D_1 = 3'd3;  // acc.d  * base.d
  localparam logic [OpW-1:0] OP_BAS_B_0 = 3'd4;  // base.a * base.b
  localparam logic [OpW-1:0] OP_BAS_B_1 = 3'd5;  // base.b * base.d
  localparam logic [OpW-1:0] OP_BAS_D_0 = 3'd6;  // base.b * base.b
  localparam logic [OpW-1:0] OP_BAS_D_1 = 3'd7;  // base.d * base.d

  // Target entry codes (upper bits of a product code)
  localparam logic [1:0] TGT_ACC_B = 2'd0;
  localparam logic [1:0] TGT_ACC_D = 2'd1;
  localparam logic [1:0] TGT_BAS_B = 2'd2;
  localparam logic [1:0] TGT_BAS_D = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic           load;         // take a new index, set up the matrices
    logic           issue;        // start one 64-bit product
    logic [OpW-1:0] op;           // which product
    logic           commit;       // close one exponent bit, shift exponent
    logic           commit_acc;   // accumulator was updated this bit
    logic           commit_base;  // base was squared this bit
    logic           out_load;     // move the answer into the output register
  } fbmp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic e_zero;       // no exponent bits left
    logic e_bit0;       // current exponent bit
    logic e_rest_zero;  // no set bits above the current one
  } fbmp_sts_t;

endpackage

### hdl/fbmp_mul_lo.sv
// Two-stage pipelined 64x64 multiplier that keeps the low 64 bits, built from 32x32 partial products.
module fbmp_mul_lo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [fbmp_pkg::OpW-1:0]   in_op,
  input  logic [fbmp_pkg::FibW-1:0]  x,
  input  logic [fbmp_pkg::FibW-1:0]  y,
  output logic                       out_valid,
  output logic [fbmp_pkg::OpW-1:0]   out_op,
  output logic [fbmp_pkg::FibW-1:0]  out_prod
);

  logic [63:0] ll_full;
  logic [63:0] lh_full;
  logic [63:0] hl_full;
  logic [63:0] ll_r;
  logic [31:0] lh_r;
  logic [31:0] hl_r;
  logic        v1_r;
  logic        v2_r;
  logic [fbmp_pkg::OpW-1:0] op1_r;
  logic [fbmp_pkg::OpW-1:0] op2_r;
  logic [31:0] cross_sum;
  logic [63:0] prod_nxt;
  logic [63:0] prod_r;

  // Partial products; the high-by-high term falls outside the low 64 bits
  assign ll_full = 64'(x[31:0])  * 64'(y[31:0]);
  assign lh_full = 64'(x[31:0])  * 64'(y[63:32]);
  assign hl_full = 64'(x[63:32]) * 64'(y[31:0]);

  // Stage one: register the partial products
  always_ff @(posedge clk) begin
    ll_r  <= ll_full;
    lh_r  <= lh_full[31:0];
    hl_r  <= hl_full[31:0];
    op1_r <= in_op;
  end

  // Stage two: fold the cross terms into the upper half
  assign cross_sum = lh_r + hl_r;
  assign prod_nxt  = ll_r + {cross_sum, 32'd0};

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    op2_r  <= op1_r;
  end

  // Track valid beats through both stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  assign out_valid = v2_r;
  assign out_op    = op2_r;
  assign out_prod  = prod_r;

endmodule

### hdl/fbmp_datapath.sv
// Datapath: exponent register, accumulator and base matrices, shared multiplier, output register.
module fbmp_datapath #(
  parameter int unsigned INDEX_BITS = fbmp_pkg::DefIndexBits
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [fbmp_pkg::IndexW-1:0]  in_index,
  input  fbmp_pkg::fbmp_cmd_t          cmd,
  output fbmp_pkg::fbmp_sts_t          sts,
  output logic [fbmp_pkg::FibW-1:0]    out_fib,
  output logic                         out_wrap
);

  localparam int unsigned ExpW = (INDEX_BITS < fbmp_pkg::IndexW) ? INDEX_BITS : fbmp_pkg::IndexW;
  localparam logic [fbmp_pkg::IndexW-1:0] IdxMask =
    (INDEX_BITS >= fbmp_pkg::IndexW) ? {fbmp_pkg::IndexW{1'b1}}
                                     : 32'((64'd1 << INDEX_BITS) - 64'd1);

  logic [fbmp_pkg::IndexW-1:0] n_m;
  logic [fbmp_pkg::IndexW-1:0] n_dec;
  logic [ExpW-1:0]             e_r;

  // Matrices {{a,b},{b,d}}; every power of the step matrix is symmetric
  logic [63:0] acc_a_r, acc_b_r, acc_d_r;
  logic [63:0] bas_a_r, bas_b_r, bas_d_r;
  logic [63:0] new_ab_r, new_ad_r, new_bb_r, new_bd_r;
  logic [63:0] half_r;
  logic        wrap_r;
  logic [63:0] out_fib_r;
  logic        out_wrap_r;

  logic [63:0] mx, my;
  logic        pv;
  logic [fbmp_pkg::OpW-1:0] pop;
  logic [63:0] prod;
  logic [63:0] sum;

  assign n_m   = in_index & IdxMask;
  assign n_dec = n_m - 32'd1;

  // Select the operand pair for the product being issued
  always_comb begin
    unique case (cmd.op)
      fbmp_pkg::OP_ACC_B_0: begin mx = acc_a_r; my = bas_b_r; end
      fbmp_pkg::OP_ACC_B_1: begin mx = acc_b_r; my = bas_d_r; end
      fbmp_pkg::OP_ACC_D_0: begin mx = acc_b_r; my = bas_b_r; end
      fbmp_pkg::OP_ACC_D_1: begin mx = acc_d_r; my = bas_d_r; end
      fbmp_pkg::OP_BAS_B_0: begin mx = bas_a_r; my = bas_b_r; end
      fbmp_pkg::OP_BAS_B_1: begin mx = bas_b_r; my = bas_d_r; end
      fbmp_pkg::OP_BAS_D_0: begin mx = bas_b_r; my = bas_b_r; end
      fbmp_pkg::OP_BAS_D_1: begin mx = bas_d_r; my = bas_d_r; end
      default:              begin mx = bas_d_r; my = bas_d_r; end
    endcase
  end

  fbmp_mul_lo u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cmd.issue),
    .in_op     (cmd.op),
    .x         (mx),
    .y         (my),
    .out_valid (pv),
    .out_op    (pop),
    .out_prod  (prod)
  );

  assign sum = half_r + prod;

  // Pair up products: hold the first term, write the sum on the second
  always_ff @(posedge clk) begin
    if (pv) begin
      if (!pop[0]) begin
        half_r <= prod;
      end else begin
        case (pop[2:1])
          fbmp_pkg::TGT_ACC_B: new_ab_r <= sum;
          fbmp_pkg::TGT_ACC_D: new_ad_r <= sum;
          fbmp_pkg::TGT_BAS_B: new_bb_r <= sum;
          default:             new_bd_r <= sum;
        endcase
      end
    end
  end

  // Set up, then advance one exponent bit per commit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      e_r     <= (n_m == '0) ? '0 : n_dec[ExpW-1:0];
      wrap_r  <= (n_m > fbmp_pkg::FibLastExact);
      acc_a_r <= 64'd1;
      acc_b_r <= 64'd0;
      acc_d_r <= (n_m == '0) ? 64'd0 : 64'd1;
      bas_a_r <= 64'd0;
      bas_b_r <= 64'd1;
      bas_d_r <= 64'd1;
    end else if (cmd.commit) begin
      e_r <= e_r >> 1;
      if (cmd.commit_acc) begin
        acc_a_r <= new_ad_r - new_ab_r;
        acc_b_r <= new_ab_r;
        acc_d_r <= new_ad_r;
      end
      if (cmd.commit_base) begin
        bas_a_r <= new_bd_r - new_bb_r;
        bas_b_r <= new_bb_r;
        bas_d_r <= new_bd_r;
      end
    end
  end

  // Hold the answer while the next item runs
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_fib_r  <= acc_d_r;
      out_wrap_r <= wrap_r;
    end
  end

  assign sts.e_zero      = (e_r == '0);
  assign sts.e_bit0      = e_r[0];
  assign sts.e_rest_zero = (e_r[ExpW-1:1] == '0);

  assign out_fib  = out_fib_r;
  assign out_wrap = out_wrap_r;

endmodule

### hdl/fbmp_ctrl.sv
// Controller: sequences product issue per exponent bit and runs both stream handshakes.
module fbmp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  fbmp_pkg::fbmp_sts_t  sts,
  output fbmp_pkg::fbmp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_BIT    = 3'd1;
  localparam logic [2:0] S_ISSUE  = 3'd2;
  localparam logic [2:0] S_WAIT   = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [2:0] k_r, k_nxt;
  logic       w_r, w_nxt;
  logic       use_acc_r, use_acc_nxt;
  logic       use_bas_r, use_bas_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       last_issue;
  logic       out_free;

  assign last_issue = (k_r == fbmp_pkg::OP_BAS_D_1) ||
                      ((k_r == fbmp_pkg::OP_ACC_D_1) && !use_bas_r);
  assign out_free   = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    w_nxt         = w_r;
    use_acc_nxt   = use_acc_r;
    use_bas_nxt   = use_bas_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.op        = k_r;

    // Drop the output beat once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_BIT;
        end
      end
      S_BIT: begin
        // Decide which products this bit needs
        if (sts.e_zero) begin
          state_nxt = S_DONE;
        end else begin
          use_acc_nxt = sts.e_bit0;
          use_bas_nxt = !sts.e_rest_zero;
          k_nxt       = sts.e_bit0 ? fbmp_pkg::OP_ACC_B_0 : fbmp_pkg::OP_BAS_B_0;
          state_nxt   = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        if (last_issue) begin
          w_nxt     = 1'b0;
          state_nxt = S_WAIT;
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
      S_WAIT: begin
        // Let the last product leave the multiplier pipeline
        w_nxt = 1'b1;
        if (w_r) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit      = 1'b1;
        cmd.commit_acc  = use_acc_r;
        cmd.commit_base = use_bas_r;
        state_nxt       = S_BIT;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    w_r       <= w_nxt;
    use_acc_r <= use_acc_nxt;
    use_bas_r <= use_bas_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

### hdl/fibonacci_by_matrix_power.sv
// Top level: Fibonacci(n) modulo 2^64 by binary powering of the 2x2 step matrix.
//
//   channel | direction | beat contents
//   in_     | slave     | tdata[31:0] index_n
//   out_    | master    | tdata[63:0] fib_value, tuser[0] wrapped
//
// One item at a time. Per bit position of n-1 up to its highest set bit,
// a bit takes a decide step, 4 or 8 product issues, a pipeline drain and a
// commit; the issues are bound by the single shared 64-bit multiplier,
// which takes one product per cycle.
// rst_n is synchronous; it clears the sequencer and the output valid.
// A result waiting on out_tready does not block the next accepted item.
module fibonacci_by_matrix_power #(
  parameter int unsigned INDEX_BITS = fbmp_pkg::DefIndexBits
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] index_n
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] fib_value
  output logic [0:0]  out_tuser   // [0] wrapped
);

  fbmp_pkg::fbmp_cmd_t cmd;
  fbmp_pkg::fbmp_sts_t sts;
  logic [fbmp_pkg::FibW-1:0] fib;
  logic                      wrap;

  fbmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fbmp_datapath #(
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_index (in_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .out_fib  (fib),
    .out_wrap (wrap)
  );

  assign out_tdata    = fib;
  assign out_tuser[0] = wrap;

endmodule
